// File: design/hbsd_pkg.sv
// hbsd_pkg: request codes, status codes and field widths of the prefix-code decoder
// used by the channel interfaces and the decoder top level
`timescale 1ns / 1ps

package hbsd_pkg;

    localparam int ACTION_W = 2;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 6;
    localparam int SYM_W    = 32;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DECODE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

endpackage

// File: design/hbsd_ifs.sv
// hbsd_in_if and hbsd_out_if: valid/ready channels for requests and results
// depends on hbsd_pkg for field widths
`timescale 1ns / 1ps

interface hbsd_in_if;
    import hbsd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [WORD_W-1:0]          code_word;
    logic [LEN_W-1:0]           code_length;
    logic signed [SYM_W-1:0]    symbol_in;
    logic                       stream_bit;
    logic                       stream_end;

    modport source (
        output valid, action, code_word, code_length, symbol_in, stream_bit, stream_end,
        input  ready
    );
    modport sink (
        input  valid, action, code_word, code_length, symbol_in, stream_bit, stream_end,
        output ready
    );
endinterface

interface hbsd_out_if;
    import hbsd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       symbol_valid;
    logic signed [SYM_W-1:0]    symbol_out;
    logic [STATUS_W-1:0]        status;

    modport source (
        output valid, symbol_valid, symbol_out, status,
        input  ready
    );
    modport sink (
        input  valid, symbol_valid, symbol_out, status,
        output ready
    );
endinterface

// File: design/hbsd_node_ram.sv
// hbsd_node_ram: node store, one write port and one read port, registered read data
// no dependencies
`timescale 1ns / 1ps

module hbsd_node_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 51
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/huffman_bit_serial_decoder.sv
// Prefix-code (Huffman tree) decoder. The tree lives in a node memory of MAX_NODES
// entries; the root's two child links sit in registers, and a copy of the current
// decode node's links is kept beside the walk position. A decode request picks the
// child from the registered links and starts the node memory read, then tests that
// node for a leaf; a bit with no child finishes as no match once it is accepted. A
// clear finishes once accepted. A load is accepted and then walks the code bits: a
// bit that follows an existing branch reads the node memory and then steps, a bit
// that creates a node steps at once, and a final step marks the leaf. The code
// length is capped at MAX_CODE_LEN; a load that runs out of pool nodes finishes at
// that bit. A held result stalls completion, not a request's acceptance while idle.
// depends on hbsd_pkg, hbsd_ifs, hbsd_node_ram
`timescale 1ns / 1ps

module huffman_bit_serial_decoder #(
    parameter int MAX_NODES    = 512,
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_BITS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hbsd_in_if.sink       i_in,
    hbsd_out_if.source    o_out
);
    import hbsd_pkg::*;

    localparam int IW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);

    typedef struct packed {
        logic [IW-1:0]          zc;
        logic [IW-1:0]          oc;
        logic                   leaf;
        logic [SYMBOL_BITS-1:0] val;
    } t_node;

    localparam int EW = $bits(t_node);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LWALK  = 5'b00010,
        S_LFETCH = 5'b00100,
        S_DFETCH = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [IW-1:0]          r_root_z, n_root_z;
    logic [IW-1:0]          r_root_o, n_root_o;
    logic [NW-1:0]          r_used, n_used;
    logic [IW-1:0]          r_walk, n_walk;
    logic [IW-1:0]          r_wz, n_wz;
    logic [IW-1:0]          r_wo, n_wo;
    logic [IW-1:0]          r_cur, n_cur;
    t_node                  r_img, n_img;
    logic                   r_dirty, n_dirty;
    logic [LW-1:0]          r_cnt, n_cnt;
    logic [WORD_W-1:0]      r_word, n_word;
    logic [SYMBOL_BITS-1:0] r_sym, n_sym;
    logic [IW-1:0]          r_next, n_next;
    logic                   r_end, n_end;
    logic                   r_res_sv, n_res_sv;
    logic signed [SYM_W-1:0] r_res_sym, n_res_sym;
    logic [STATUS_W-1:0]    r_res_st, n_res_st;
    logic                   r_ov, n_ov;
    logic                   r_o_sv, n_o_sv;
    logic signed [SYM_W-1:0] r_o_sym, n_o_sym;
    logic [STATUS_W-1:0]    r_o_st, n_o_st;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    t_node                  ram_wdata;
    logic [IW-1:0]          ram_raddr;
    t_node                  ram_rdata;
    logic [EW-1:0]          ram_rbits;

    logic                   acc;
    logic                   out_free;
    logic                   fin;
    logic                   fin_sv;
    logic signed [SYM_W-1:0] fin_sym;
    logic [STATUS_W-1:0]    fin_st;
    logic [IW-1:0]          dec_child;
    logic [LW-1:0]          pos;
    logic [WORD_W-1:0]      word_sh;
    logic                   lbit;
    logic [IW-1:0]          lchild;
    logic                   full;
    logic [IW-1:0]          new_idx;
    t_node                  upd;

    hbsd_node_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = t_node'(ram_rbits);

    assign i_in.ready         = (r_state == S_IDLE);
    assign acc                = i_in.valid && i_in.ready;
    assign out_free           = !r_ov || o_out.ready;
    assign o_out.valid        = r_ov;
    assign o_out.symbol_valid = r_o_sv;
    assign o_out.symbol_out   = r_o_sym;
    assign o_out.status       = r_o_st;

    // child for a decode bit, root links or the copy of the current node's links
    always_comb begin
        if (r_walk == '0) begin
            dec_child = i_in.stream_bit ? r_root_o : r_root_z;
        end else begin
            dec_child = i_in.stream_bit ? r_wo : r_wz;
        end
    end

    // load walk: code bit at position count minus one
    assign pos     = r_cnt - LW'(1);
    assign word_sh = r_word >> pos;
    assign lbit    = word_sh[0];
    assign lchild  = lbit ? r_img.oc : r_img.zc;
    assign full    = (r_used == NW'(MAX_NODES));
    assign new_idx = r_used[IW-1:0];

    always_comb begin
        upd = r_img;
        if (lbit) begin
            upd.oc = new_idx;
        end else begin
            upd.zc = new_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_root_z  = r_root_z;
        n_root_o  = r_root_o;
        n_used    = r_used;
        n_walk    = r_walk;
        n_wz      = r_wz;
        n_wo      = r_wo;
        n_cur     = r_cur;
        n_img     = r_img;
        n_dirty   = r_dirty;
        n_cnt     = r_cnt;
        n_word    = r_word;
        n_sym     = r_sym;
        n_next    = r_next;
        n_end     = r_end;
        n_res_sv  = r_res_sv;
        n_res_sym = r_res_sym;
        n_res_st  = r_res_st;
        n_ov      = r_ov && !o_out.ready;
        n_o_sv    = r_o_sv;
        n_o_sym   = r_o_sym;
        n_o_st    = r_o_st;
        ram_we    = 1'b0;
        ram_waddr = r_cur;
        ram_wdata = r_img;
        ram_raddr = '0;
        fin       = 1'b0;
        fin_sv    = 1'b0;
        fin_sym   = '0;
        fin_st    = ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_in.action)
                        ACT_CLEAR: begin
                            n_root_z = '0;
                            n_root_o = '0;
                            n_used   = NW'(1);
                            n_walk   = '0;
                            fin      = 1'b1;
                        end
                        ACT_LOAD: begin
                            n_cur   = '0;
                            n_img   = '{zc: r_root_z, oc: r_root_o, leaf: 1'b0, val: '0};
                            n_dirty = 1'b0;
                            if (int'(i_in.code_length) > MAX_CODE_LEN) begin
                                n_cnt = LW'(MAX_CODE_LEN);
                            end else begin
                                n_cnt = LW'(i_in.code_length);
                            end
                            n_word  = i_in.code_word;
                            n_sym   = SYMBOL_BITS'(i_in.symbol_in);
                            n_state = S_LWALK;
                        end
                        ACT_DECODE: begin
                            if (dec_child == '0) begin
                                fin    = 1'b1;
                                fin_st = ST_NO_MATCH;
                                n_walk = '0;
                            end else begin
                                ram_raddr = dec_child;
                                n_next    = dec_child;
                                n_end     = i_in.stream_end;
                                n_state   = S_DFETCH;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_LWALK: begin
                if (r_cnt == '0) begin
                    // root leaf is never tested, so only pool nodes are marked
                    if (r_cur != '0) begin
                        ram_we         = 1'b1;
                        ram_wdata.leaf = 1'b1;
                        ram_wdata.val  = r_sym;
                    end
                    fin = 1'b1;
                end else if (lchild != '0) begin
                    ram_raddr = lchild;
                    n_cur     = lchild;
                    n_cnt     = r_cnt - LW'(1);
                    n_state   = S_LFETCH;
                end else if (full) begin
                    // a fresh node not yet stored still needs its empty entry
                    ram_we = r_dirty;
                    fin    = 1'b1;
                    fin_st = ST_FULL;
                end else begin
                    if (r_cur == '0) begin
                        n_root_z = upd.zc;
                        n_root_o = upd.oc;
                    end else begin
                        ram_we    = 1'b1;
                        ram_wdata = upd;
                    end
                    n_cur   = new_idx;
                    n_img   = '0;
                    n_dirty = 1'b1;
                    n_used  = r_used + NW'(1);
                    n_cnt   = r_cnt - LW'(1);
                end
            end
            S_LFETCH: begin
                n_img   = ram_rdata;
                n_dirty = 1'b0;
                n_state = S_LWALK;
            end
            S_DFETCH: begin
                fin = 1'b1;
                if (ram_rdata.leaf) begin
                    fin_sv  = 1'b1;
                    fin_sym = SYM_W'(signed'(ram_rdata.val));
                    n_walk  = '0;
                end else if (r_end) begin
                    fin_st = ST_INCOMPLETE;
                    n_walk = '0;
                end else begin
                    n_walk = r_next;
                    n_wz   = ram_rdata.zc;
                    n_wo   = ram_rdata.oc;
                end
            end
            S_DONE: begin
                fin     = 1'b1;
                fin_sv  = r_res_sv;
                fin_sym = r_res_sym;
                fin_st  = r_res_st;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // keep the walk node's link copy coherent with loads that extend it
        if (ram_we && (ram_waddr == r_walk) && (r_walk != '0)) begin
            n_wz = ram_wdata.zc;
            n_wo = ram_wdata.oc;
        end

        if (fin) begin
            if (out_free) begin
                n_ov    = 1'b1;
                n_o_sv  = fin_sv;
                n_o_sym = fin_sym;
                n_o_st  = fin_st;
                n_state = S_IDLE;
            end else begin
                n_res_sv  = fin_sv;
                n_res_sym = fin_sym;
                n_res_st  = fin_st;
                n_state   = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_root_z <= '0;
            r_root_o <= '0;
            r_used   <= NW'(1);
            r_walk   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_root_z <= n_root_z;
            r_root_o <= n_root_o;
            r_used   <= n_used;
            r_walk   <= n_walk;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wz      <= n_wz;
        r_wo      <= n_wo;
        r_cur     <= n_cur;
        r_img     <= n_img;
        r_dirty   <= n_dirty;
        r_cnt     <= n_cnt;
        r_word    <= n_word;
        r_sym     <= n_sym;
        r_next    <= n_next;
        r_end     <= n_end;
        r_res_sv  <= n_res_sv;
        r_res_sym <= n_res_sym;
        r_res_st  <= n_res_st;
        r_o_sv    <= n_o_sv;
        r_o_sym   <= n_o_sym;
        r_o_st    <= n_o_st;
    end

    // pool count stays within the node store
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != '0) && (int'(r_used) <= MAX_NODES))
        else $error("node count out of range");

    // the walk only ever sits on an allocated node
    a_walk_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_walk) < r_used)
        else $error("walk position beyond allocated nodes");

    // the root is held in registers and never written to the node store
    a_no_root_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr != '0))
        else $error("node store write to root entry");

    // a decode with an existing child goes on to the leaf test
    a_decode_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_in.action == ACT_DECODE) && (dec_child != '0)) |=> (r_state == S_DFETCH))
        else $error("decode request did not fetch its child node");

endmodule

// File: sim/huffman_bit_serial_decoder_tb.sv
// huffman_bit_serial_decoder_tb: self-checking bench for the prefix-code tree decoder
// runs a table of directed requests, then random load/decode sessions, scored against
// typed rows or a tree model here; depends on hbsd_pkg, hbsd_ifs, the decoder top level
`timescale 1ns / 1ps

module huffman_bit_serial_decoder_tb;
    import hbsd_pkg::*;

    localparam int MAX_NODES    = 512;
    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_BITS  = 32;

    localparam int RESET_CYCLES = 7;
    localparam int ITEM_TARGET  = 1650;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int FILL_LOADS   = 24;
    localparam int DIR_ROWS     = 25;

    // the package names no code for the unused action
    localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [WORD_W-1:0]       code_word;
        logic [LEN_W-1:0]        code_length;
        logic signed [SYM_W-1:0] symbol_in;
        logic                    stream_bit;
        logic                    stream_end;
    } t_request;

    typedef struct packed {
        logic                    symbol_valid;
        logic signed [SYM_W-1:0] symbol_out;
        logic [STATUS_W-1:0]     status;
    } t_result;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [WORD_W-1:0]       code_word;
        logic [LEN_W-1:0]        code_length;
        logic signed [SYM_W-1:0] symbol_in;
        logic                    stream_bit;
        logic                    stream_end;
        logic                    fixed;
        logic                    want_valid;
        logic signed [SYM_W-1:0] want_symbol;
        logic [STATUS_W-1:0]     want_status;
    } t_directed_row;

    // columns: action, word, length, symbol, bit, end | typed?, valid, symbol, status
    localparam t_directed_row DIRECTED [DIR_ROWS] = '{
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b0, 1'b0, 1'b1, 1'b0, 32'h0,
          ST_NO_MATCH},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b1, 1'b1, 1'b1, 1'b0, 32'h0,
          ST_NO_MATCH},
        '{ACT_UNDEFINED, 32'hffff_ffff, 6'd63, 32'hffff_ffff, 1'b1, 1'b1,
          1'b1, 1'b0, 32'h0, ST_OK},
        '{ACT_LOAD,      32'h0, 6'd1,  32'h7fff_ffff, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
        '{ACT_LOAD,      32'h2, 6'd2,  32'h8000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
        '{ACT_LOAD,      32'h3, 6'd2,  32'hffff_ffff, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b0, 1'b0, 1'b1, 1'b1, 32'h7fff_ffff,
          ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b1, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b0, 1'b1, 1'b1, 1'b1, 32'h8000_0000,
          ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b1, 1'b1, 1'b1, 1'b0, 32'h0,
          ST_INCOMPLETE},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b1, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b1, 1'b0, 1'b1, 1'b1, 32'hffff_ffff,
          ST_OK},
        '{ACT_LOAD,      32'h0, 6'd0,  32'h5,        1'b0, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b0, 1'b0, 1'b1, 1'b1, 32'h7fff_ffff,
          ST_OK},
        '{ACT_LOAD,      32'h0, 6'd1,  32'h4d2,      1'b0, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b0, 1'b1, 1'b0, 1'b0, 32'h0, ST_OK},
        '{ACT_LOAD,      32'hffff_ffff, 6'd63, 32'h55aa, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{ACT_LOAD,      32'hffff_ffff, 6'd32, 32'hffff_fffe, 1'b0, 1'b0,
          1'b0, 1'b0, 32'h0, ST_OK},
        '{ACT_LOAD,      32'h1, 6'd32, 32'h0,        1'b0, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{ACT_CLEAR,     32'h0, 6'd0,  32'h0,        1'b0, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b0, 1'b1, 1'b1, 1'b0, 32'h0,
          ST_NO_MATCH},
        '{ACT_LOAD,      32'h5, 6'd3,  32'h0,        1'b0, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b1, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b0, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{ACT_DECODE,    32'h0, 6'd0,  32'h0,        1'b1, 1'b1, 1'b1, 1'b1, 32'h0, ST_OK}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    hbsd_in_if  req_ch ();
    hbsd_out_if rsp_ch ();

    huffman_bit_serial_decoder #(
        .MAX_NODES    (MAX_NODES),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_BITS  (SYMBOL_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // tree model
    int                      tree_zero  [MAX_NODES];
    int                      tree_one   [MAX_NODES];
    logic                    tree_leaf  [MAX_NODES];
    logic signed [SYM_W-1:0] tree_value [MAX_NODES];
    int                      pool_count = 1;
    int                      walk_node  = 0;

    t_result           awaited_results [$];
    logic [WORD_W-1:0] session_words   [$];
    int                session_lens    [$];

    int  error_count    = 0;
    int  requests_sent  = 0;
    int  symbols_seen   = 0;
    int  no_match_seen  = 0;
    int  incomplete_seen = 0;
    int  full_seen      = 0;
    int  session_count  = 0;
    bit  gaps_on        = 1'b1;
    bit  quiet          = 1'b0;
    bit  hold_pending   = 1'b0;

    function automatic t_result tree_step(input t_request r);
        t_result                       res;
        int                            cur;
        int                            nxt;
        int                            len;
        int                            pos;
        logic                          b;
        logic signed [SYMBOL_BITS-1:0] cut;
        res = '0;
        case (r.action)
            ACT_CLEAR: begin
                tree_zero[0]  = 0;
                tree_one[0]   = 0;
                tree_leaf[0]  = 1'b0;
                tree_value[0] = '0;
                pool_count    = 1;
                walk_node     = 0;
            end
            ACT_LOAD: begin
                len = (r.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(r.code_length);
                cur = 0;
                for (pos = len - 1; pos >= 0 && res.status == ST_OK; pos--) begin
                    b   = (pos < WORD_W) ? r.code_word[pos] : 1'b0;
                    nxt = b ? tree_one[cur] : tree_zero[cur];
                    if (nxt == 0 && pool_count >= MAX_NODES) begin
                        res.status = ST_FULL;
                    end else begin
                        if (nxt == 0) begin
                            nxt = pool_count;
                            pool_count++;
                            tree_zero[nxt]  = 0;
                            tree_one[nxt]   = 0;
                            tree_leaf[nxt]  = 1'b0;
                            tree_value[nxt] = '0;
                            if (b) tree_one[cur] = nxt;
                            else   tree_zero[cur] = nxt;
                        end
                        cur = nxt;
                    end
                end
                if (res.status == ST_OK) begin
                    cut = r.symbol_in[SYMBOL_BITS-1:0];
                    tree_leaf[cur]  = 1'b1;
                    tree_value[cur] = cut;
                end
            end
            ACT_DECODE: begin
                nxt = r.stream_bit ? tree_one[walk_node] : tree_zero[walk_node];
                if (nxt == 0) begin
                    res.status = ST_NO_MATCH;
                    walk_node  = 0;
                end else if (tree_leaf[nxt]) begin
                    res.symbol_valid = 1'b1;
                    res.symbol_out   = tree_value[nxt];
                    walk_node        = 0;
                end else if (r.stream_end) begin
                    res.status = ST_INCOMPLETE;
                    walk_node  = 0;
                end else begin
                    walk_node = nxt;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_request make_req(input logic [ACTION_W-1:0] action,
                                          input logic [WORD_W-1:0] word,
                                          input logic [LEN_W-1:0] len,
                                          input logic signed [SYM_W-1:0] sym,
                                          input logic b, input logic e);
        t_request r;
        r.action      = action;
        r.code_word   = word;
        r.code_length = len;
        r.symbol_in   = sym;
        r.stream_bit  = b;
        r.stream_end  = e;
        return r;
    endfunction

    // present one request, hold it until taken, then queue what it should produce
    task automatic offer(input t_request r, input bit fixed = 1'b0,
                         input t_result typed = '0);
        t_result res;
        if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= r.action;
        req_ch.code_word   <= r.code_word;
        req_ch.code_length <= r.code_length;
        req_ch.symbol_in   <= r.symbol_in;
        req_ch.stream_bit  <= r.stream_bit;
        req_ch.stream_end  <= r.stream_end;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        res = tree_step(r);
        if (fixed) res = typed;
        awaited_results = {awaited_results, res};
        if (r.action != ACT_UNDEFINED) requests_sent++;
        quiet = requests_sent > ITEM_TARGET * 17 / 20;
        if (res.symbol_valid) symbols_seen++;
        case (res.status)
            ST_NO_MATCH:   no_match_seen++;
            ST_INCOMPLETE: incomplete_seen++;
            ST_FULL:       full_seen++;
            default: ;
        endcase
    endtask

    task automatic send_code(input logic [WORD_W-1:0] w, input int n, input bit mark_end);
        int pos;
        for (pos = n - 1; pos >= 0; pos--)
            offer(make_req(ACT_DECODE, $urandom, LEN_W'($urandom), $urandom, w[pos],
                           mark_end && pos == 0));
    endtask

    // clear, load a code set, then decode a stream built mostly from that set
    task automatic run_session(input bit fill_pool, input bit squeeze);
        int                n_loads;
        int                n_words;
        int                len;
        int                k;
        int                i;
        int                pick;
        logic [WORD_W-1:0] w;
        session_words.delete();
        session_lens.delete();
        offer(make_req(ACT_CLEAR, $urandom, LEN_W'($urandom), $urandom,
                       1'($urandom), 1'($urandom)));
        n_loads = fill_pool ? FILL_LOADS : $urandom_range(2, 12);
        for (i = 0; i < n_loads; i++) begin
            k = $urandom_range(0, 19);
            if (fill_pool)   len = MAX_CODE_LEN;
            else if (k < 16) len = $urandom_range(1, 8);
            else if (k < 19) len = $urandom_range(9, 24);
            else             len = $urandom_range(0, 63);
            w = $urandom;
            offer(make_req(ACT_LOAD, w, LEN_W'(len), $urandom, 1'($urandom), 1'($urandom)));
            if (len > 0) begin
                session_words = {session_words, w};
                session_lens  = {session_lens, (len > MAX_CODE_LEN ? MAX_CODE_LEN : len)};
            end
        end
        if (squeeze) hold_pending = 1'b1;
        n_words = $urandom_range(15, 45);
        for (i = 0; i < n_words && requests_sent < ITEM_TARGET; i++) begin
            k    = $urandom_range(0, 19);
            pick = $urandom_range(0, session_lens.size() - 1);
            if (session_lens.size() == 0 || k == 18)
                offer(make_req(ACT_DECODE, $urandom, LEN_W'($urandom), $urandom,
                               1'($urandom), 1'($urandom)));
            else if (k == 19)
                offer(make_req(ACT_UNDEFINED, $urandom, LEN_W'($urandom), $urandom,
                               1'($urandom), 1'($urandom)));
            else if (k < 16)
                send_code(session_words[pick], session_lens[pick], i == n_words - 1);
            else
                // possibly cut short, and marked as the end of the stream
                send_code(session_words[pick], $urandom_range(1, session_lens[pick]), 1'b1);
        end
    endtask

    initial begin : stimulus
        int            row;
        t_directed_row d;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_CLEAR;
        req_ch.code_word   <= '0;
        req_ch.code_length <= '0;
        req_ch.symbol_in   <= '0;
        req_ch.stream_bit  <= 1'b0;
        req_ch.stream_end  <= 1'b0;
        i_rst_n            <= 1'b0;
        tree_zero[0]  = 0;
        tree_one[0]   = 0;
        tree_leaf[0]  = 1'b0;
        tree_value[0] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIR_ROWS; row++) begin
            d = DIRECTED[row];
            offer(make_req(d.action, d.code_word, d.code_length, d.symbol_in,
                           d.stream_bit, d.stream_end),
                  d.fixed, t_result'{d.want_valid, d.want_symbol, d.want_status});
        end

        while (requests_sent < ITEM_TARGET) begin
            gaps_on = $urandom_range(0, 3) != 0;
            run_session(session_count % 6 == 0, session_count == 1);
            session_count++;
        end
        req_ch.valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests over %0d sessions after the directed table",
                 requests_sent, session_count);
        $display("  %0d symbols, %0d no-match, %0d incomplete, %0d table-full results",
                 symbols_seen, no_match_seen, incomplete_seen, full_seen);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result side: short random stalls, plus one long hold-off so the input backs up
    initial begin : result_stall
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: symbol_valid %0b symbol_out %0d status %0d",
                       rsp_ch.symbol_valid, rsp_ch.symbol_out, rsp_ch.status);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (rsp_ch.symbol_valid !== want.symbol_valid) begin
                    $error("symbol_valid: expected %0b, got %0b",
                           want.symbol_valid, rsp_ch.symbol_valid);
                    error_count++;
                end
                if (rsp_ch.symbol_out !== want.symbol_out) begin
                    $error("symbol_out: expected %0d, got %0d", want.symbol_out,
                           rsp_ch.symbol_out);
                    error_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
